// File: design/ssa_def_use_checker_assert.svh
// ----------------------------------------------------------------------------
// ssa_def_use_checker assertion macros
// Concurrent assertion wrappers for the checker; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SSA_DEF_USE_CHECKER_ASSERT_SVH
`define SSA_DEF_USE_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SDU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SDU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: design/sdu_pkg.sv
// ----------------------------------------------------------------------------
// sdu_pkg
// Shared widths, codes and port bundles of the SSA def-use checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sdu_pkg;

  // field widths
  localparam int REG_W     = 11;
  localparam int REG_IDX_W = 10;
  localparam int IMM_W     = 32;
  localparam int IDX_W     = 16;
  localparam int STAT_W    = 4;
  localparam int FUNC_W    = 3;

  // register field value meaning "unused"
  localparam logic signed [REG_W-1:0] REG_NONE = '1;

  // instruction index saturates at min(65535, MAX_INSTRS - 1)
  localparam longint unsigned MAX_INSTRS = 64'd65536;
  localparam logic [IDX_W-1:0] IDX_LIMIT =
    ((MAX_INSTRS - 64'd1) < 64'd65535) ? IDX_W'(MAX_INSTRS - 64'd1) : '1;

  // epoch tags: zero marks a swept entry, live epochs run 1..max
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] TAG_CLEAR   = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_CONST = 3'd0,
    FN_ADD   = 3'd1,
    FN_SUB   = 3'd2,
    FN_MUL   = 3'd3,
    FN_RET   = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 4'd0,
    ST_UNUSED      = 4'd1,
    ST_CONST_NEG   = 4'd2,
    ST_CONST_REDEF = 4'd3,
    ST_BIN_DST_NEG = 4'd4,
    ST_BIN_REDEF   = 4'd5,
    ST_BIN_OPD_NEG = 4'd6,
    ST_BIN_UNDEF   = 4'd7,
    ST_RET_NEG     = 4'd8,
    ST_RET_UNDEF   = 4'd9,
    ST_NO_RET      = 4'd10,
    ST_RANGE       = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    PH_CLEAR,
    PH_RUN,
    PH_DRAIN
  } phase_t;

  // bitmap read request (issued on the accept edge)
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] addr_d;
    logic [REG_IDX_W-1:0] addr_l;
    logic [REG_IDX_W-1:0] addr_r;
  } map_rd_t;

  // bitmap write (define or sweep)
  typedef struct packed {
    logic                 en;
    logic                 fwd;
    logic [REG_IDX_W-1:0] addr;
    logic [EPOCH_W-1:0]   tag;
  } map_wr_t;

  // defined flags of the three register fields
  typedef struct packed {
    logic d;
    logic l;
    logic r;
  } map_def_t;

  function automatic logic [EPOCH_W-1:0] next_epoch(input logic [EPOCH_W-1:0] e);
    logic [EPOCH_W-1:0] n;
    n = (e == EPOCH_MAX) ? EPOCH_FIRST : e + 1'b1;
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/sdu_if.sv
// ----------------------------------------------------------------------------
// sdu_if
// Valid/ready channels of the checker: instruction in, status out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdu_in_if;
  logic                              valid;
  logic                              ready;
  logic [sdu_pkg::FUNC_W-1:0]        func;
  logic signed [sdu_pkg::REG_W-1:0]  dest_reg;
  logic signed [sdu_pkg::REG_W-1:0]  left_reg;
  logic signed [sdu_pkg::REG_W-1:0]  right_reg;
  logic signed [sdu_pkg::IMM_W-1:0]  immediate;
  logic                              last;

  modport source (output valid, func, dest_reg, left_reg, right_reg, immediate, last,
                  input ready);
  modport sink   (input valid, func, dest_reg, left_reg, right_reg, immediate, last,
                  output ready);
endinterface

interface sdu_out_if;
  logic                        valid;
  logic                        ready;
  logic [sdu_pkg::STAT_W-1:0]  status;
  logic [sdu_pkg::IDX_W-1:0]   fail_index;
  logic                        done_res;

  modport source (output valid, status, fail_index, done_res, input ready);
  modport sink   (input valid, status, fail_index, done_res, output ready);
endinterface

`default_nettype wire

// File: design/sdu_def_map.sv
// ----------------------------------------------------------------------------
// sdu_def_map
// Defined-register bitmap held as epoch tags in two synchronous RAM copies.
// ----------------------------------------------------------------------------
`default_nettype none

module sdu_def_map #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdu_pkg::map_rd_t              rd,
  input  sdu_pkg::map_wr_t              wr,
  input  logic [sdu_pkg::EPOCH_W-1:0]   epoch,
  output sdu_pkg::map_def_t             def
);
  import sdu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // copy A serves dest and left, copy B serves right
  logic [EPOCH_W-1:0] mem_a [DEPTH];
  logic [EPOCH_W-1:0] mem_b [DEPTH];

  logic [EPOCH_W-1:0] tag_d_r, tag_l_r, tag_r_r;
  logic [AW-1:0]      addr_d_r, addr_l_r, addr_r_r;
  logic [AW-1:0]      fw_addr_r;
  logic               fw_v_r;

  // RAM copy A
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.addr[AW-1:0]] <= wr.tag;
    end
    if (rd.en) begin
      tag_d_r <= mem_a[rd.addr_d[AW-1:0]];
      tag_l_r <= mem_a[rd.addr_l[AW-1:0]];
    end
  end

  // RAM copy B
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_b[wr.addr[AW-1:0]] <= wr.tag;
    end
    if (rd.en) begin
      tag_r_r <= mem_b[rd.addr_r[AW-1:0]];
    end
  end

  // read addresses, and the define landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      addr_d_r  <= rd.addr_d[AW-1:0];
      addr_l_r  <= rd.addr_l[AW-1:0];
      addr_r_r  <= rd.addr_r[AW-1:0];
      fw_addr_r <= wr.addr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_v_r <= 1'b0;
    end else if (rd.en) begin
      fw_v_r <= wr.en && wr.fwd;
    end
  end

  // live tag or forwarded define
  assign def.d = (tag_d_r == epoch) || (fw_v_r && (fw_addr_r == addr_d_r));
  assign def.l = (tag_l_r == epoch) || (fw_v_r && (fw_addr_r == addr_l_r));
  assign def.r = (tag_r_r == epoch) || (fw_v_r && (fw_addr_r == addr_r_r));

endmodule

`default_nettype wire

// File: design/ssa_def_use_checker.sv
// ----------------------------------------------------------------------------
// ssa_def_use_checker
// Single-assignment and define-before-use checker for three-address programs.
// ----------------------------------------------------------------------------
// The checker takes one instruction beat per clock while the output is not
// stalled and no sweep or drain runs, and returns one status beat per
// instruction via the stage-1 and output registers. The defined-register
// bitmap lives in a synchronous RAM as per-program epoch tags; a define
// landing on the same edge as the next instruction's read is forwarded, so
// back-to-back instructions need not stall for it. Ending a program only
// advances the epoch. A sweep of min(NUM_REGS, 1024) entries, with the input
// held off, runs after reset and again after every 255th program when the
// 8-bit epoch wraps. The first error of a program is latched with its index;
// a beat marked last returns the final status and starts a fresh program.
`default_nettype none

`include "ssa_def_use_checker_assert.svh"

module ssa_def_use_checker #(
  parameter int NUM_REGS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  sdu_in_if.sink     in_ch,
  sdu_out_if.source  out_ch
);
  import sdu_pkg::*;

  // only register numbers below 1024 can be encoded
  localparam int DEPTH  = (NUM_REGS < (2 ** REG_IDX_W)) ? NUM_REGS : (2 ** REG_IDX_W);
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NREG_W = 17;
  localparam logic [NREG_W-1:0] NREG = NREG_W'(NUM_REGS);

  // control
  phase_t             phase_r, phase_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [EPOCH_W-1:0] acc_epoch_r, acc_epoch_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               in_ready;
  logic               acc;
  logic               s1_adv;

  // stage 1 (RAM read data valid)
  logic                     s1_v_r;
  logic [FUNC_W-1:0]        s1_func_r;
  logic signed [REG_W-1:0]  s1_dst_r, s1_lft_r, s1_rgt_r;
  logic                     s1_imm_nz_r;
  logic                     s1_last_r;

  // program state
  status_t            err_code_r, err_code_nxt;
  logic [IDX_W-1:0]   err_idx_r, err_idx_nxt;
  logic [IDX_W-1:0]   instr_idx_r, instr_idx_nxt;
  logic               ret_seen_r, ret_seen_nxt;

  // output register
  logic               out_v_r;
  status_t            out_status_r;
  logic [IDX_W-1:0]   out_fail_r;
  logic               out_done_r;

  // check results
  map_rd_t            map_rd;
  map_wr_t            map_wr;
  map_def_t           map_def;
  status_t            chk_code;
  logic               chk_def;
  logic               chk_ret;
  status_t            new_code;
  logic [IDX_W-1:0]   new_eidx;
  logic               new_ret;
  logic               d_none, l_none, r_none;
  logic               d_neg, l_neg, r_neg;
  logic               d_oor, l_oor, r_oor;

  // handshake
  assign s1_adv   = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = (phase_r == PH_RUN) && (!s1_v_r || s1_adv);
  assign acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // phase sequencer: sweep, run, drain before a wrap sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CLEAR;
      clr_cnt_r   <= '0;
      acc_epoch_r <= EPOCH_FIRST;
    end else begin
      phase_r     <= phase_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      acc_epoch_r <= acc_epoch_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    clr_cnt_nxt   = clr_cnt_r;
    acc_epoch_nxt = acc_epoch_r;
    if (acc && in_ch.last) begin
      acc_epoch_nxt = next_epoch(acc_epoch_r);
    end
    unique case (phase_r)
      PH_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_cnt_nxt = '0;
          phase_nxt   = PH_RUN;
        end
      end
      PH_RUN: begin
        if (acc && in_ch.last && (acc_epoch_r == EPOCH_MAX)) begin
          phase_nxt = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        if (!s1_v_r) begin
          phase_nxt = PH_CLEAR;
        end
      end
      default: phase_nxt = PH_CLEAR;
    endcase
  end

  // bitmap read on accept
  assign map_rd.en     = acc;
  assign map_rd.addr_d = in_ch.dest_reg[REG_IDX_W-1:0];
  assign map_rd.addr_l = in_ch.left_reg[REG_IDX_W-1:0];
  assign map_rd.addr_r = in_ch.right_reg[REG_IDX_W-1:0];

  // bitmap write: sweep or define
  always_comb begin
    if (phase_r == PH_CLEAR) begin
      map_wr.en   = 1'b1;
      map_wr.fwd  = 1'b0;
      map_wr.addr = REG_IDX_W'(clr_cnt_r);
      map_wr.tag  = TAG_CLEAR;
    end else begin
      map_wr.en   = s1_adv && (err_code_r == ST_OK) && chk_def;
      map_wr.fwd  = !s1_last_r;
      map_wr.addr = s1_dst_r[REG_IDX_W-1:0];
      map_wr.tag  = epoch_r;
    end
  end

  sdu_def_map #(
    .DEPTH (DEPTH)
  ) u_def_map (
    .clk   (clk),
    .rst_n (rst_n),
    .rd    (map_rd),
    .wr    (map_wr),
    .epoch (epoch_r),
    .def   (map_def)
  );

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_func_r   <= in_ch.func;
      s1_dst_r    <= in_ch.dest_reg;
      s1_lft_r    <= in_ch.left_reg;
      s1_rgt_r    <= in_ch.right_reg;
      s1_imm_nz_r <= (in_ch.immediate != '0);
      s1_last_r   <= in_ch.last;
    end
  end

  // field classification
  assign d_none = (s1_dst_r == REG_NONE);
  assign l_none = (s1_lft_r == REG_NONE);
  assign r_none = (s1_rgt_r == REG_NONE);
  assign d_neg  = s1_dst_r[REG_W-1];
  assign l_neg  = s1_lft_r[REG_W-1];
  assign r_neg  = s1_rgt_r[REG_W-1];
  assign d_oor  = !d_neg && (NREG_W'(s1_dst_r[REG_IDX_W-1:0]) >= NREG);
  assign l_oor  = !l_neg && (NREG_W'(s1_lft_r[REG_IDX_W-1:0]) >= NREG);
  assign r_oor  = !r_neg && (NREG_W'(s1_rgt_r[REG_IDX_W-1:0]) >= NREG);

  // per-instruction check, first failing rule wins
  always_comb begin
    chk_code = ST_OK;
    chk_def  = 1'b0;
    chk_ret  = 1'b0;
    unique case (s1_func_r)
      FN_CONST: begin
        priority if (!l_none || !r_none) chk_code = ST_UNUSED;
        else if (d_neg)                  chk_code = ST_CONST_NEG;
        else if (d_oor)                  chk_code = ST_RANGE;
        else if (map_def.d)              chk_code = ST_CONST_REDEF;
        else                             chk_def  = 1'b1;
      end
      FN_ADD, FN_SUB, FN_MUL: begin
        priority if (s1_imm_nz_r)           chk_code = ST_UNUSED;
        else if (d_neg)                     chk_code = ST_BIN_DST_NEG;
        else if (d_oor)                     chk_code = ST_RANGE;
        else if (map_def.d)                 chk_code = ST_BIN_REDEF;
        else if (l_neg || r_neg)            chk_code = ST_BIN_OPD_NEG;
        else if (l_oor || r_oor)            chk_code = ST_RANGE;
        else if (!map_def.l || !map_def.r)  chk_code = ST_BIN_UNDEF;
        else                                chk_def  = 1'b1;
      end
      FN_RET: begin
        if (!d_none || !r_none || s1_imm_nz_r) begin
          chk_code = ST_UNUSED;
        end else begin
          chk_ret = 1'b1;
          priority if (l_neg) chk_code = ST_RET_NEG;
          else if (l_oor)     chk_code = ST_RANGE;
          else if (!map_def.l) chk_code = ST_RET_UNDEF;
          else                chk_code = ST_OK;
        end
      end
      default: chk_code = ST_UNUSED;
    endcase
  end

  // latch first error, missing ret on last
  always_comb begin
    new_code = err_code_r;
    new_eidx = err_idx_r;
    new_ret  = ret_seen_r;
    if (err_code_r == ST_OK) begin
      if (chk_ret) begin
        new_ret = 1'b1;
      end
      if (chk_code != ST_OK) begin
        new_code = chk_code;
        new_eidx = instr_idx_r;
      end
    end
    if (s1_last_r && (new_code == ST_OK) && !new_ret) begin
      new_code = ST_NO_RET;
      new_eidx = instr_idx_r;
    end
  end

  // program state update; last starts a new program
  always_comb begin
    err_code_nxt  = err_code_r;
    err_idx_nxt   = err_idx_r;
    instr_idx_nxt = instr_idx_r;
    ret_seen_nxt  = ret_seen_r;
    epoch_nxt     = epoch_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        err_code_nxt  = ST_OK;
        err_idx_nxt   = '0;
        instr_idx_nxt = '0;
        ret_seen_nxt  = 1'b0;
        epoch_nxt     = next_epoch(epoch_r);
      end else begin
        err_code_nxt = new_code;
        err_idx_nxt  = new_eidx;
        ret_seen_nxt = new_ret;
        if (instr_idx_r < IDX_LIMIT) begin
          instr_idx_nxt = instr_idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_code_r  <= ST_OK;
      err_idx_r   <= '0;
      instr_idx_r <= '0;
      ret_seen_r  <= 1'b0;
      epoch_r     <= EPOCH_FIRST;
    end else begin
      err_code_r  <= err_code_nxt;
      err_idx_r   <= err_idx_nxt;
      instr_idx_r <= instr_idx_nxt;
      ret_seen_r  <= ret_seen_nxt;
      epoch_r     <= epoch_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= new_code;
      out_fail_r   <= (new_code != ST_OK) ? new_eidx : '0;
      out_done_r   <= s1_last_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.fail_index = out_fail_r;
  assign out_ch.done_res   = out_done_r;

  // checks
  `SDU_ASSERT_NOW(a_sweep_pipe_empty, clk, rst_n, phase_r == PH_CLEAR, !s1_v_r, "sweep with instruction in flight")
  `SDU_ASSERT_NOW(a_epoch_agree, clk, rst_n, !s1_v_r, acc_epoch_r == epoch_r, "accept and commit epochs disagree")
  `SDU_ASSERT_NOW(a_epoch_live, clk, rst_n, 1'b1, epoch_r != TAG_CLEAR, "epoch equals swept tag")
  `SDU_ASSERT_NEXT(a_last_resets, clk, rst_n, s1_adv && s1_last_r, (err_code_r == ST_OK) && (instr_idx_r == '0) && !ret_seen_r, "program state not cleared after last")

endmodule

`default_nettype wire
